[rtl/pvb_pkg.sv]
// Shared definitions for the polar vector blend: CORDIC constants, arctangent
// table, command codes and the controller/datapath handshake structs.
// No dependencies.
package pvb_pkg;

    localparam int LENGTH_BITS_DEF  = 16;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Extra fraction bits carried on lengths inside the CORDIC
    localparam int GUARD        = 8;
    // 1/K^2 in Q1.30, K = CORDIC gain; scaled down by 2^(30-GUARD) on entry
    localparam int KINV2_BITS   = 29;
    localparam logic [KINV2_BITS-1:0] KINV2 = 29'd395948876;
    localparam int KINV2_SHIFT  = 30 - GUARD;

    // Internal angle: 32-bit binary angle plus headroom, signed
    localparam int ZW = 34;
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sh4000_0000);
    localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'sh8000_0000);

    localparam int WEIGHT_BITS = 17;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE   = 17'd65536;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 17'd52429;

    // Step index covers the full arctangent table
    localparam int STEP_IDX_W = 5;

    localparam logic CMD_FORCE   = 1'b0;
    localparam logic CMD_HEADING = 1'b1;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic                  load_in;    // load CORDIC from input ports
        logic                  load_force; // store force vector from ports
        logic                  save_h;     // keep heading xy, load force vector
        logic                  step;       // one CORDIC iteration
        logic                  vec_mode;   // vectoring direction rule
        logic [STEP_IDX_W-1:0] step_idx;
        logic                  blend_x;
        logic                  blend_y;
        logic                  blend_end;
        logic                  vec_init;
        logic                  out_load;
    } pvb_cmd_t;

    typedef struct packed {
        logic out_free;
    } pvb_sts_t;

endpackage

[rtl/polar_vector_blend_top.sv]
// A force transfer (command 0) stores a magnitude and direction and
// produces no result. A heading transfer (command 1) yields one result: the
// length and angle of w*heading + (1-w)*force, w = blend_weight in Q1.16
// (values above 1.0 act as 1.0). A heading passes through the single CORDIC
// stage, which runs the heading rotation, the force rotation and the
// vectoring pass one after another; the input is not ready in that time. The
// finished result sits in an output register, so the next transfer is taken
// while it waits; a heading that finishes while the previous result is still
// unread holds until it is taken. blend_weight is written through the cfg
// channel, which is always ready; the user must write it only while the block
// is idle, and the block itself does not enforce this.
// Depends on pvb_pkg, pvb_ctrl and pvb_datapath.
module polar_vector_blend_top #(
    parameter int LENGTH_BITS  = pvb_pkg::LENGTH_BITS_DEF,
    parameter int ANGLE_BITS   = pvb_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = pvb_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_command,
    input  logic [LENGTH_BITS-1:0]          s_vec_length,
    input  logic [ANGLE_BITS-1:0]           s_vec_angle,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [LENGTH_BITS-1:0]          m_out_length,
    output logic [ANGLE_BITS-1:0]           m_out_angle,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pvb_pkg::WEIGHT_BITS-1:0] cfg_wdata
);

    pvb_pkg::pvb_cmd_t cmd;
    pvb_pkg::pvb_sts_t sts;

    assign cfg_ready = 1'b1;

    pvb_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pvb_datapath #(
        .LENGTH_BITS (LENGTH_BITS),
        .ANGLE_BITS  (ANGLE_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_vec_length (s_vec_length),
        .s_vec_angle  (s_vec_angle),
        .cfg_valid    (cfg_valid),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .sts          (sts),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_length (m_out_length),
        .m_out_angle  (m_out_angle)
    );

endmodule

[rtl/pvb_ctrl.sv]
// Sequencer for the polar vector blend: steps the shared CORDIC through two
// rotations, the blend and one vectoring pass.
// Depends on pvb_pkg.
module pvb_ctrl #(
    parameter int CORDIC_STEPS = pvb_pkg::CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_command,
    output logic               s_ready,
    input  pvb_pkg::pvb_sts_t  sts,
    output pvb_pkg::pvb_cmd_t  cmd
);

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b0000000001,
        ST_ROT_H     = 10'b0000000010,
        ST_LOAD_F    = 10'b0000000100,
        ST_ROT_F     = 10'b0000001000,
        ST_BLEND_X   = 10'b0000010000,
        ST_BLEND_Y   = 10'b0000100000,
        ST_BLEND_END = 10'b0001000000,
        ST_VEC_INIT  = 10'b0010000000,
        ST_VEC       = 10'b0100000000,
        ST_FINISH    = 10'b1000000000
    } state_t;

    localparam logic [pvb_pkg::STEP_IDX_W-1:0] LAST_STEP =
        pvb_pkg::STEP_IDX_W'(CORDIC_STEPS - 1);

    state_t                          state_reg, state_next;
    logic [pvb_pkg::STEP_IDX_W-1:0]  cnt_reg, cnt_next;
    logic                            last_step;

    assign last_step = (cnt_reg == LAST_STEP);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.step_idx = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_command == pvb_pkg::CMD_HEADING) begin
                        cmd.load_in = 1'b1;
                        cnt_next    = '0;
                        state_next  = ST_ROT_H;
                    end else begin
                        cmd.load_force = 1'b1;
                    end
                end
            end
            ST_ROT_H: begin
                cmd.step = 1'b1;
                cnt_next = last_step ? '0 : cnt_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_LOAD_F;
                end
            end
            ST_LOAD_F: begin
                cmd.save_h = 1'b1;
                state_next = ST_ROT_F;
            end
            ST_ROT_F: begin
                cmd.step = 1'b1;
                cnt_next = last_step ? '0 : cnt_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_BLEND_X;
                end
            end
            ST_BLEND_X: begin
                cmd.blend_x = 1'b1;
                state_next  = ST_BLEND_Y;
            end
            ST_BLEND_Y: begin
                cmd.blend_y = 1'b1;
                state_next  = ST_BLEND_END;
            end
            ST_BLEND_END: begin
                cmd.blend_end = 1'b1;
                state_next    = ST_VEC_INIT;
            end
            ST_VEC_INIT: begin
                cmd.vec_init = 1'b1;
                state_next   = ST_VEC;
            end
            ST_VEC: begin
                cmd.step     = 1'b1;
                cmd.vec_mode = 1'b1;
                cnt_next     = last_step ? '0 : cnt_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded while output register still occupied");

    a_one_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_in, cmd.load_force, cmd.save_h, cmd.step, cmd.blend_x,
                  cmd.blend_y, cmd.blend_end, cmd.vec_init, cmd.out_load}))
        else $error("more than one datapath command in a cycle");

    a_heading_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_command == pvb_pkg::CMD_HEADING))
            |=> (state_reg == ST_ROT_H) && (cnt_reg == '0))
        else $error("heading transfer did not start rotation at step zero");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (cnt_reg <= LAST_STEP))
        else $error("CORDIC step index beyond configured step count");

endmodule

[rtl/pvb_datapath.sv]
// Datapath for the polar vector blend: shared CORDIC stage, blend multiplier,
// force and weight registers, output register.
// Depends on pvb_pkg.
module pvb_datapath #(
    parameter int LENGTH_BITS = pvb_pkg::LENGTH_BITS_DEF,
    parameter int ANGLE_BITS  = pvb_pkg::ANGLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [LENGTH_BITS-1:0]              s_vec_length,
    input  logic [ANGLE_BITS-1:0]               s_vec_angle,
    input  logic                                cfg_valid,
    input  logic [pvb_pkg::WEIGHT_BITS-1:0]     cfg_wdata,
    input  pvb_pkg::pvb_cmd_t                   cmd,
    output pvb_pkg::pvb_sts_t                   sts,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [LENGTH_BITS-1:0]              m_out_length,
    output logic [ANGLE_BITS-1:0]               m_out_angle
);

    localparam int XW     = LENGTH_BITS + 11;
    localparam int ZW     = pvb_pkg::ZW;
    localparam int PW     = XW + 19;
    localparam int EW     = LENGTH_BITS + pvb_pkg::KINV2_BITS;
    localparam int ASHIFT = 32 - ANGLE_BITS;
    localparam logic [32:0] AROUND = (33'd1 << ASHIFT) >> 1;
    localparam logic [XW:0] LROUND = (XW+1)'(1) << (pvb_pkg::GUARD - 1);

    logic [pvb_pkg::WEIGHT_BITS-1:0] weight_reg;
    logic [LENGTH_BITS-1:0]          force_mag_reg;
    logic [ANGLE_BITS-1:0]           force_dir_reg;
    logic signed [XW-1:0]            x_reg, y_reg, xh_reg, yh_reg;
    logic signed [XW-1:0]            x_next, y_next;
    logic signed [ZW-1:0]            z_reg, z_next;
    logic signed [PW-1:0]            prod_reg;
    logic                            zero_reg;
    logic                            m_valid_reg;
    logic [LENGTH_BITS-1:0]          out_len_reg;
    logic [ANGLE_BITS-1:0]           out_ang_reg;

    // entry conversion: scale length by 1/K^2, fold angle to +-quarter turn
    logic [LENGTH_BITS-1:0]  src_len;
    logic [ANGLE_BITS-1:0]   src_ang;
    logic [EW-1:0]           ent_prod;
    logic signed [XW-1:0]    ent_x0, ent_x;
    logic [31:0]             ent_a32;
    logic signed [ZW-1:0]    ent_z0, ent_z;

    assign src_len  = cmd.save_h ? force_mag_reg : s_vec_length;
    assign src_ang  = cmd.save_h ? force_dir_reg : s_vec_angle;
    assign ent_prod = EW'(src_len) * EW'(pvb_pkg::KINV2);
    assign ent_x0   = signed'(XW'(ent_prod >> pvb_pkg::KINV2_SHIFT));
    assign ent_a32  = 32'(src_ang) << ASHIFT;
    assign ent_z0   = ZW'(signed'(ent_a32));

    always_comb begin
        ent_x = ent_x0;
        ent_z = ent_z0;
        if (ent_z0 > pvb_pkg::QUARTER_TURN) begin
            ent_x = -ent_x0;
            ent_z = ent_z0 - pvb_pkg::HALF_TURN;
        end else if (ent_z0 < -pvb_pkg::QUARTER_TURN) begin
            ent_x = -ent_x0;
            ent_z = ent_z0 + pvb_pkg::HALF_TURN;
        end
    end

    // CORDIC iteration, same update for rotation and vectoring
    logic signed [XW-1:0] sh_x, sh_y;
    logic signed [ZW-1:0] atan_val;
    logic                 dir_up;

    assign sh_x     = x_reg >>> cmd.step_idx;
    assign sh_y     = y_reg >>> cmd.step_idx;
    assign atan_val = signed'(ZW'(pvb_pkg::ATAN_TURNS[cmd.step_idx]));
    assign dir_up   = cmd.vec_mode ? y_reg[XW-1] : !z_reg[ZW-1];

    // blend: f + w*(h - f) / 2^16, floor
    logic [pvb_pkg::WEIGHT_BITS-1:0] w_clamp;
    logic signed [XW:0]              bl_diff;
    logic signed [XW-1:0]            bl_sum;

    assign w_clamp = (weight_reg > pvb_pkg::WEIGHT_ONE) ? pvb_pkg::WEIGHT_ONE : weight_reg;
    assign bl_diff = cmd.blend_x ? ((XW+1)'(xh_reg) - (XW+1)'(x_reg))
                                 : ((XW+1)'(yh_reg) - (XW+1)'(y_reg));
    assign bl_sum  = (cmd.blend_y ? x_reg : y_reg) + XW'(prod_reg >>> 16);

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (cmd.load_in || cmd.save_h) begin
            x_next = ent_x;
            y_next = '0;
            z_next = ent_z;
        end else if (cmd.step) begin
            x_next = dir_up ? x_reg - sh_y : x_reg + sh_y;
            y_next = dir_up ? y_reg + sh_x : y_reg - sh_x;
            z_next = dir_up ? z_reg - atan_val : z_reg + atan_val;
        end else if (cmd.blend_y) begin
            x_next = bl_sum;
        end else if (cmd.blend_end) begin
            y_next = bl_sum;
        end else if (cmd.vec_init) begin
            // flip left half plane by a half turn
            if (x_reg[XW-1]) begin
                x_next = -x_reg;
                y_next = -y_reg;
                z_next = pvb_pkg::HALF_TURN;
            end else begin
                z_next = '0;
            end
        end
    end

    // result rounding and saturation
    logic [XW:0]             len_sum;
    logic [XW-pvb_pkg::GUARD:0] len_q;
    logic [LENGTH_BITS-1:0]  len_out;
    logic [32:0]             ang_sum, ang_q;
    logic [ANGLE_BITS-1:0]   ang_out;

    assign len_sum = {1'b0, x_reg} + LROUND;
    assign len_q   = len_sum[XW:pvb_pkg::GUARD];
    assign ang_sum = {1'b0, z_reg[31:0]} + AROUND;
    assign ang_q   = ang_sum >> ASHIFT;

    always_comb begin
        if (zero_reg || x_reg[XW-1]) begin
            len_out = '0;
        end else if (|len_q[XW-pvb_pkg::GUARD:LENGTH_BITS]) begin
            len_out = '1;
        end else begin
            len_out = len_q[LENGTH_BITS-1:0];
        end
        ang_out = zero_reg ? '0 : ang_q[ANGLE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (cmd.save_h) begin
            xh_reg <= x_reg;
            yh_reg <= y_reg;
        end
        if (cmd.blend_x || cmd.blend_y) begin
            prod_reg <= PW'(bl_diff) * PW'(signed'({1'b0, w_clamp}));
        end
        if (cmd.vec_init) begin
            zero_reg <= (x_reg == '0) && (y_reg == '0);
        end
        if (cmd.out_load) begin
            out_len_reg <= len_out;
            out_ang_reg <= ang_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg    <= pvb_pkg::WEIGHT_RESET;
            force_mag_reg <= '0;
            force_dir_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                weight_reg <= cfg_wdata;
            end
            if (cmd.load_force) begin
                force_mag_reg <= s_vec_length;
                force_dir_reg <= s_vec_angle;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_free  = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_out_length  = out_len_reg;
    assign m_out_angle   = out_ang_reg;

endmodule

[test/tb_polar_vector_blend_top.sv]
`timescale 1ns / 1ps
// Testbench for polar_vector_blend_top: force and heading transfers are checked
// against a CORDIC blend predictor kept in a small scoreboard class.
// Depends on pvb_pkg and the polar_vector_blend_top RTL.
module tb_polar_vector_blend_top;

    localparam int SETTLE_CYCLES = 64;
    localparam int SEG_ITEMS     = 94;
    localparam int SEGMENTS      = 9;
    localparam int ROT_STEPS     = 16;
    localparam int MAX_PRINTED   = 100;
    localparam longint KINV2_Q30 = 64'd395948876;
    localparam longint HALF      = 64'h8000_0000;
    localparam longint QUARTER   = 64'h4000_0000;

    typedef struct packed {
        logic [15:0] length;
        logic [15:0] angle;
    } polar_t;

    class blend_scoreboard;
        logic [pvb_pkg::WEIGHT_BITS-1:0] heading_weight;
        logic [15:0] force_mag;
        logic [15:0] force_dir;
        polar_t      expected_polar[$];
        int          mismatches;

        function new();
            heading_weight = pvb_pkg::WEIGHT_RESET;
            force_mag      = '0;
            force_dir      = '0;
            mismatches     = 0;
        endfunction

        // atan(2^-i) in 2^-32 turn units
        function longint atan_q32(int i);
            case (i)
                0:       return 64'h20000000;
                1:       return 64'h12E4051E;
                2:       return 64'h09FB385B;
                3:       return 64'h051111D4;
                4:       return 64'h028B0D43;
                5:       return 64'h0145D7E1;
                6:       return 64'h00A2F61E;
                7:       return 64'h00517C55;
                8:       return 64'h0028BE53;
                9:       return 64'h00145F2F;
                10:      return 64'h000A2F98;
                11:      return 64'h000517CC;
                12:      return 64'h00028BE6;
                13:      return 64'h000145F3;
                14:      return 64'h0000A2FA;
                15:      return 64'h0000517D;
                default: return 64'h0;
            endcase
        endfunction

        function void rotate_to_xy(logic [15:0] len, logic [15:0] ang,
                                   output longint x, output longint y);
            longint l;
            longint z;
            longint dx;
            longint dy;
            l = {48'h0, len};
            x = (l * KINV2_Q30) >>> 22;
            y = 0;
            z = {32'h0, ang, 16'h0000};
            if (z >= HALF) z = z - 2 * HALF;
            // fold into the right half plane
            if (z > QUARTER) begin
                x = -x;
                z = z - HALF;
            end else if (z < -QUARTER) begin
                x = -x;
                z = z + HALF;
            end
            for (int i = 0; i < ROT_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_q32(i);
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_q32(i);
                end
            end
        endfunction

        function polar_t vector_to_polar(longint xin, longint yin);
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            longint rl;
            longint t;
            polar_t r;
            x = xin;
            y = yin;
            z = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = HALF;
            end
            for (int i = 0; i < ROT_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y < 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_q32(i);
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_q32(i);
                end
            end
            if (x < 0) x = 0;
            rl = (x + 128) >>> 8;
            if (rl > 65535) rl = 65535;
            t = {32'h0, z[31:0]};
            t = t + 32768;
            r.length = rl[15:0];
            r.angle  = t[31:16];
            return r;
        endfunction

        function polar_t predict_blend(logic [15:0] len, logic [15:0] ang);
            longint w;
            longint xh;
            longint yh;
            longint xf;
            longint yf;
            longint xb;
            longint yb;
            polar_t r;
            w = (heading_weight > pvb_pkg::WEIGHT_ONE) ? 65536 : {47'h0, heading_weight};
            rotate_to_xy(len, ang, xh, yh);
            rotate_to_xy(force_mag, force_dir, xf, yf);
            xb = (w * xh + (65536 - w) * xf) >>> 16;
            yb = (w * yh + (65536 - w) * yf) >>> 16;
            // a blend that cancels out reports length 0 at angle 0
            if (xb == 0 && yb == 0) r = '0;
            else r = vector_to_polar(xb, yb);
            return r;
        endfunction

        function void note_transfer(logic cmd, logic [15:0] len, logic [15:0] ang);
            if (cmd == pvb_pkg::CMD_FORCE) begin
                force_mag = len;
                force_dir = ang;
            end else begin
                expected_polar.push_back(predict_blend(len, ang));
            end
        endfunction

        task report_mismatch(string what);
            if (mismatches < MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic [15:0] len, logic [15:0] ang);
            polar_t exp_r;
            if (expected_polar.size() == 0) begin
                report_mismatch($sformatf("result %h/%h with nothing expected", len, ang));
            end else begin
                exp_r = expected_polar.pop_front();
                if (len !== exp_r.length)
                    report_mismatch($sformatf("out_length %h, want %h", len, exp_r.length));
                if (ang !== exp_r.angle)
                    report_mismatch($sformatf("out_angle %h, want %h", ang, exp_r.angle));
            end
        endtask

        task drain_check();
            while (expected_polar.size() != 0) begin
                void'(expected_polar.pop_front());
                report_mismatch("expected result never arrived");
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_command;
    logic [15:0] s_vec_length;
    logic [15:0] s_vec_angle;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_out_length;
    logic [15:0] m_out_angle;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [pvb_pkg::WEIGHT_BITS-1:0] cfg_wdata;

    int src_idle_pct;
    int sink_idle_pct;

    blend_scoreboard sb = new();

    polar_vector_blend_top uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_vec_length (s_vec_length),
        .s_vec_angle  (s_vec_angle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_length (m_out_length),
        .m_out_angle  (m_out_angle),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_wdata    (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_out_length, m_out_angle);
    end

    initial begin
        #(5_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_item(logic cmd, logic [15:0] len, logic [15:0] ang);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_vec_length <= len;
        s_vec_angle  <= ang;
        do @(posedge aclk); while (!s_ready);
        sb.note_transfer(cmd, len, ang);
    endtask

    // drop valid, then hold until every heading has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_polar.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_weight(logic [pvb_pkg::WEIGHT_BITS-1:0] w);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= w;
        do @(posedge aclk); while (!cfg_ready);
        sb.heading_weight = w;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_length();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(255));
            3:       return 16'($urandom_range(4095));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        logic [15:0] a;
        if ($urandom_range(3) == 0) begin
            // land near a quadrant boundary
            a = {2'($urandom_range(3)), 14'h0};
            a = a + 16'($urandom_range(4)) - 16'd2;
        end else begin
            a = 16'($urandom_range(65535));
        end
        return a;
    endfunction

    task automatic send_random();
        logic cmd;
        cmd = ($urandom_range(9) < 4) ? pvb_pkg::CMD_FORCE : pvb_pkg::CMD_HEADING;
        send_item(cmd, pick_length(), pick_angle());
    endtask

    initial begin
        logic [pvb_pkg::WEIGHT_BITS-1:0] weights [SEGMENTS];
        weights = '{17'd0, 17'd65536, 17'd131071, 17'd32768, 17'd1,
                    17'd65537, 17'd65535, 17'($urandom_range(65536)), 17'd52429};
        s_valid       = 1'b0;
        s_command     = pvb_pkg::CMD_FORCE;
        s_vec_length  = '0;
        s_vec_angle   = '0;
        cfg_valid     = 1'b0;
        cfg_wdata     = '0;
        aresetn       = 1'b0;
        src_idle_pct  = 8;
        sink_idle_pct = 77;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset weight, zero force: both vectors zero, then heading alone
        send_item(pvb_pkg::CMD_HEADING, 16'h0000, 16'h0000);
        send_item(pvb_pkg::CMD_HEADING, 16'hFFFF, 16'h0000);
        send_item(pvb_pkg::CMD_HEADING, 16'h0100, 16'h4000);
        send_item(pvb_pkg::CMD_HEADING, 16'h0100, 16'h8000);
        send_item(pvb_pkg::CMD_HEADING, 16'h0100, 16'hC000);
        send_item(pvb_pkg::CMD_HEADING, 16'h0100, 16'hFFFF);
        send_item(pvb_pkg::CMD_HEADING, 16'h0100, 16'h3FFF);
        send_item(pvb_pkg::CMD_HEADING, 16'h0100, 16'h4001);
        send_item(pvb_pkg::CMD_HEADING, 16'h0100, 16'hBFFF);
        send_item(pvb_pkg::CMD_HEADING, 16'h0100, 16'hC001);
        // largest lengths in line: output saturates
        send_item(pvb_pkg::CMD_FORCE,   16'hFFFF, 16'h0000);
        send_item(pvb_pkg::CMD_HEADING, 16'hFFFF, 16'h0000);
        send_item(pvb_pkg::CMD_FORCE,   16'hFFFF, 16'h8000);
        send_item(pvb_pkg::CMD_HEADING, 16'hFFFF, 16'h8000);
        send_item(pvb_pkg::CMD_HEADING, 16'hFFFF, 16'h0000);
        send_item(pvb_pkg::CMD_FORCE,   16'h1234, 16'h2000);
        send_item(pvb_pkg::CMD_HEADING, 16'h0000, 16'h0000);
        send_item(pvb_pkg::CMD_HEADING, 16'h0001, 16'h7FFF);
        send_item(pvb_pkg::CMD_FORCE,   16'h0000, 16'hFFFF);
        send_item(pvb_pkg::CMD_HEADING, 16'h0000, 16'h1234);
        send_item(pvb_pkg::CMD_HEADING, 16'hAAAA, 16'h5555);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_drained();
            case (seg / 3)
                0: begin
                    src_idle_pct  = 8;
                    sink_idle_pct = 77;
                end
                1: begin
                    src_idle_pct  = 77;
                    sink_idle_pct = 8;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            write_weight(weights[seg]);
            for (int n = 0; n < SEG_ITEMS; n++) send_random();
        end

        wait_drained();
        sb.drain_check();
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
